// File: src/bwpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwpd_pkg
// Types and constants for the sync-word packet deframer.
// ----------------------------------------------------------------------------
package bwpd_pkg;

	typedef enum logic [2:0] {
		ST_SYNC1 = 3'd0,
		ST_SYNC2 = 3'd1,
		ST_ID    = 3'd2,
		ST_COUNT = 3'd3,
		ST_FLAGS = 3'd4,
		ST_CSUM  = 3'd5,
		ST_DATA  = 3'd6,
		ST_WAKE  = 3'd7
	} hunt_state_t;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_HDR_ERR = 2'd1,
		KIND_WAKE    = 2'd2
	} kind_t;

	localparam logic [7:0]  SYNC_BYTE_0   = 8'hFF;
	localparam logic [7:0]  SYNC_BYTE_1   = 8'h81;
	localparam logic [15:0] SYNC_WORD     = 16'h81FF;
	localparam logic [7:0]  WAKE_BYTE_0   = 8'h45;
	localparam logic [7:0]  WAKE_BYTE_1   = 8'h41;
	localparam logic        REPLY_EN_RST  = 1'b1;

endpackage

// File: src/binary_word_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_word_packet_deframer
// Byte-stream deframer: sync hunt, wake reply, header check, payload words with checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one byte per
//   transaction. Output channel (out_valid / out_stall / fields) gives at
//   most one result per accepted byte: a data word, a header checksum error
//   or a wake reply request.
//   A byte is decoded in the cycle it is accepted and its result sits in the
//   output register on the next cycle; throughput is 1 byte per cycle while
//   the receiver does not stall the output register.
//   in_stall is high only while the output register holds a result that the
//   receiver is stalling; draining that result frees the input in the same
//   cycle, so an unstalled stream runs at one byte every cycle.
//   cfg_write / cfg_data load reply_enable, which gates the wake reply.
//   Reset (arst_n low) returns the hunt to the first sync byte, empties the
//   output register and sets reply_enable to 1.
// ----------------------------------------------------------------------------
module binary_word_packet_deframer
	import bwpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] message_id,
	output logic [15:0] word_index,
	output logic [15:0] word_value,
	output logic        last,
	output logic        checksum_ok
);

	hunt_state_t state_q, state_d;
	logic        reply_en_q;
	logic        pending_q, pending_d;
	logic [7:0]  low_hold_q, low_hold_d;
	logic [15:0] cur_id_q, cur_id_d;
	logic [15:0] count_q, count_d;
	logic [15:0] hdr_sum_q, hdr_sum_d;
	logic [15:0] rcvd_q, rcvd_d;
	logic [15:0] pay_sum_q, pay_sum_d;

	logic        out_valid_q;
	kind_t       kind_q, kind_d;
	logic [15:0] id_out_q, id_out_d;
	logic [15:0] idx_out_q, idx_out_d;
	logic [15:0] val_out_q, val_out_d;
	logic        last_q, last_d;
	logic        ok_q, ok_d;

	logic        in_fire;
	logic        out_load;
	logic [15:0] word;
	logic        word_done;

	assign in_stall = out_valid_q & out_stall;
	assign in_fire  = in_valid & ~in_stall;
	assign word     = {rx_byte, low_hold_q};

	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		low_hold_d = low_hold_q;
		cur_id_d  = cur_id_q;
		count_d   = count_q;
		hdr_sum_d = hdr_sum_q;
		rcvd_d    = rcvd_q;
		pay_sum_d = pay_sum_q;
		out_load  = 1'b0;
		kind_d    = KIND_DATA;
		id_out_d  = '0;
		idx_out_d = '0;
		val_out_d = '0;
		last_d    = 1'b0;
		ok_d      = 1'b0;
		word_done = 1'b0;

		if (state_q == ST_ID || state_q == ST_COUNT || state_q == ST_FLAGS ||
		    state_q == ST_CSUM || state_q == ST_DATA) begin
			word_done = pending_q;
			pending_d = ~pending_q;
			if (!pending_q) begin
				low_hold_d = rx_byte;
			end
		end

		unique case (state_q)
			ST_SYNC1: begin
				if (rx_byte == SYNC_BYTE_0) begin
					state_d = ST_SYNC2;
				end else if (rx_byte == WAKE_BYTE_0) begin
					state_d = ST_WAKE;
				end
			end
			ST_WAKE: begin
				if (rx_byte == WAKE_BYTE_1 && reply_en_q) begin
					out_load = 1'b1;
					kind_d   = KIND_WAKE;
				end
				state_d = ST_SYNC1;
			end
			ST_SYNC2: begin
				if (rx_byte == SYNC_BYTE_1) begin
					state_d   = ST_ID;
					hdr_sum_d = SYNC_WORD;
					pending_d = 1'b0;
				end else begin
					state_d = ST_SYNC1;
				end
			end
			ST_ID: begin
				if (word_done) begin
					cur_id_d  = word;
					hdr_sum_d = hdr_sum_q + word;
					state_d   = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (word_done) begin
					count_d   = word;
					hdr_sum_d = hdr_sum_q + word;
					state_d   = ST_FLAGS;
				end
			end
			ST_FLAGS: begin
				if (word_done) begin
					hdr_sum_d = hdr_sum_q + word;
					state_d   = ST_CSUM;
				end
			end
			ST_CSUM: begin
				if (word_done) begin
					if (word == 16'(-hdr_sum_q)) begin
						state_d   = ST_DATA;
						rcvd_d    = '0;
						pay_sum_d = '0;
					end else begin
						out_load = 1'b1;
						kind_d   = KIND_HDR_ERR;
						id_out_d = cur_id_q;
						state_d  = ST_SYNC1;
					end
				end
			end
			ST_DATA: begin
				if (word_done) begin
					out_load  = 1'b1;
					kind_d    = KIND_DATA;
					id_out_d  = cur_id_q;
					idx_out_d = rcvd_q;
					val_out_d = word;
					if (rcvd_q == count_q) begin
						last_d  = 1'b1;
						ok_d    = (word == 16'(-pay_sum_q));
						state_d = ST_SYNC1;
					end else begin
						pay_sum_d = pay_sum_q + word;
						rcvd_d    = rcvd_q + 16'd1;
					end
				end
			end
			default: begin
				state_d = ST_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SYNC1;
			reply_en_q <= REPLY_EN_RST;
			pending_q  <= 1'b0;
			low_hold_q <= '0;
			cur_id_q   <= '0;
			count_q    <= '0;
			hdr_sum_q  <= '0;
			rcvd_q     <= '0;
			pay_sum_q  <= '0;
		end else begin
			if (cfg_write) begin
				reply_en_q <= cfg_data;
			end
			if (in_fire) begin
				state_q    <= state_d;
				pending_q  <= pending_d;
				low_hold_q <= low_hold_d;
				cur_id_q   <= cur_id_d;
				count_q    <= count_d;
				hdr_sum_q  <= hdr_sum_d;
				rcvd_q     <= rcvd_d;
				pay_sum_q  <= pay_sum_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && out_load) begin
			kind_q    <= kind_d;
			id_out_q  <= id_out_d;
			idx_out_q <= idx_out_d;
			val_out_q <= val_out_d;
			last_q    <= last_d;
			ok_q      <= ok_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign message_id  = id_out_q;
	assign word_index  = idx_out_q;
	assign word_value  = val_out_q;
	assign last        = last_q;
	assign checksum_ok = ok_q;

	a_ok_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!ok_q || (last_q && kind_q == KIND_DATA)))
		else $error("checksum_ok set on a word that is not last");

	a_wake_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_WAKE) |->
		(id_out_q == '0 && idx_out_q == '0 && val_out_q == '0))
		else $error("wake reply carries nonzero fields");

	a_hdr_err_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && out_load && kind_d == KIND_HDR_ERR) |=> state_q == ST_SYNC1)
		else $error("header error did not return to sync hunt");

	a_last_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && out_load && last_d) |=> (state_q == ST_SYNC1 && out_valid_q))
		else $error("last word did not end the packet");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(val_out_q) && $stable(kind_q)))
		else $error("stalled result overwritten");

endmodule
